FILE: rtl/ethp_pkg.sv
package ethp_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 248;
    localparam int OUT_TUSER_W = 2;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_ETH = 2'd1;
    localparam logic [1:0] ST_IP  = 2'd2;
    localparam logic [1:0] ST_TCP = 2'd3;

    // frame byte positions and header sizes
    localparam logic [15:0] POS_SRC_MAC  = 16'd6;
    localparam logic [15:0] POS_ETYPE    = 16'd12;
    localparam logic [15:0] POS_VER_IHL  = 16'd14;
    localparam logic [15:0] POS_PROTO    = 16'd23;
    localparam logic [15:0] POS_SRC_IP   = 16'd26;
    localparam logic [15:0] POS_DST_IP   = 16'd30;
    localparam logic [15:0] POS_IP_END   = 16'd34;
    localparam logic [7:0]  ETH_LEN      = 8'd14;
    localparam logic [15:0] IP_MIN_END   = 16'd34;
    localparam logic [15:0] TCP_MIN      = 16'd20;
    localparam logic [3:0]  HDR_MIN_WORDS = 4'd5;
    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [3:0]  IP_VERSION4  = 4'd4;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;

    // tcp header byte offsets from its start
    localparam logic [7:0] TCP_DPORT    = 8'd2;
    localparam logic [7:0] TCP_DOFF     = 8'd12;
    localparam logic [7:0] TCP_FLAGS    = 8'd13;

    typedef struct packed {
        logic [15:0] len;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ether_type;
        logic [7:0]  ver_ihl;
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] tcp_sport;
        logic [15:0] tcp_dport;
        logic [3:0]  data_off;
        logic [3:0]  flags;
    } t_frame;

endpackage

FILE: rtl/ethp_front.sv
module ethp_front #(
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output logic            o_push,
    output ethp_pkg::t_frame o_frame
);
    import ethp_pkg::*;

    t_frame r_rec;
    t_frame n_rec;
    logic [15:0] idx;
    logic [3:0]  ihl;
    logic [7:0]  tcp_base;
    logic [15:0] tcp_rel;

    assign idx      = r_rec.len;
    assign ihl      = r_rec.ver_ihl[3:0];
    assign tcp_base = ETH_LEN + {2'b00, ihl, 2'b00};
    assign tcp_rel  = idx - {8'd0, tcp_base};

    always_comb begin
        n_rec = r_rec;
        if (idx < POS_SRC_MAC) begin
            n_rec.dst_mac = {r_rec.dst_mac[39:0], i_byte};
        end else if (idx < POS_ETYPE) begin
            n_rec.src_mac = {r_rec.src_mac[39:0], i_byte};
        end else if (idx < POS_VER_IHL) begin
            n_rec.ether_type = {r_rec.ether_type[7:0], i_byte};
        end else if (idx == POS_VER_IHL) begin
            n_rec.ver_ihl = i_byte;
        end else if (idx == POS_PROTO) begin
            n_rec.protocol = i_byte;
        end else if (idx >= POS_SRC_IP && idx < POS_DST_IP) begin
            n_rec.src_ip = {r_rec.src_ip[23:0], i_byte};
        end else if (idx >= POS_DST_IP && idx < POS_IP_END) begin
            n_rec.dst_ip = {r_rec.dst_ip[23:0], i_byte};
        end

        // tcp header starts right after the ip header, as long as ihl is sane
        if (idx > POS_VER_IHL && ihl >= HDR_MIN_WORDS && idx >= {8'd0, tcp_base}) begin
            if (tcp_rel < {8'd0, TCP_DPORT}) begin
                n_rec.tcp_sport = {r_rec.tcp_sport[7:0], i_byte};
            end else if (tcp_rel < {8'd0, TCP_DPORT} + 16'd2) begin
                n_rec.tcp_dport = {r_rec.tcp_dport[7:0], i_byte};
            end else if (tcp_rel == {8'd0, TCP_DOFF}) begin
                n_rec.data_off = i_byte[7:4];
            end else if (tcp_rel == {8'd0, TCP_FLAGS}) begin
                n_rec.flags = {i_byte[4], i_byte[2:0]};
            end
        end

        if (idx < 16'(MAX_FRAME_BYTES)) begin
            n_rec.len = idx + 16'd1;
        end
    end

    assign o_push  = i_accept && i_last;
    assign o_frame = n_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_rec <= '0;
            end else begin
                r_rec <= n_rec;
            end
        end
    end

endmodule

FILE: rtl/ethp_fifo.sv
module ethp_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ethp_pkg::t_frame i_frame,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output ethp_pkg::t_frame o_frame
);
    import ethp_pkg::*;

    t_frame      r_mem [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    logic        do_push;
    logic        do_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_frame = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

FILE: rtl/ethp_back.sv
module ethp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  ethp_pkg::t_frame                    i_frame,
    output logic                                o_pop,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output logic [ethp_pkg::OUT_TDATA_W-1:0]    o_tdata,
    output logic [ethp_pkg::OUT_TUSER_W-1:0]    o_tuser
);
    import ethp_pkg::*;

    logic                    r_valid;
    logic [OUT_TDATA_W-1:0]  r_data;
    logic [OUT_TUSER_W-1:0]  r_status;
    logic [OUT_TDATA_W-1:0]  n_data;
    logic [1:0]              n_status;

    logic [15:0] len;
    logic [3:0]  ihl;
    logic [3:0]  dof;
    logic [7:0]  ip_end;
    logic [7:0]  poff;
    logic        eth_vis;
    logic        ip_vis;
    logic        tcp_vis;
    logic [7:0]  out_poff;
    logic [15:0] out_plen;

    assign len    = i_frame.len;
    assign ihl    = i_frame.ver_ihl[3:0];
    assign dof    = i_frame.data_off;
    assign ip_end = ETH_LEN + {2'b00, ihl, 2'b00};
    assign poff   = ip_end + {2'b00, dof, 2'b00};

    always_comb begin
        eth_vis  = (len >= {8'd0, ETH_LEN});
        ip_vis   = 1'b0;
        tcp_vis  = 1'b0;
        n_status = ST_ETH;
        out_poff = 8'd0;
        out_plen = 16'd0;
        if (eth_vis && i_frame.ether_type == ETYPE_IPV4) begin
            n_status = ST_IP;
            if (len >= IP_MIN_END && i_frame.ver_ihl[7:4] == IP_VERSION4) begin
                ip_vis = 1'b1;
                if (ihl >= HDR_MIN_WORDS && {8'd0, ip_end} <= len) begin
                    n_status = ST_TCP;
                    if (i_frame.protocol == PROTO_TCP &&
                        len >= {8'd0, ip_end} + TCP_MIN) begin
                        tcp_vis = 1'b1;
                        if (dof >= HDR_MIN_WORDS && {8'd0, poff} <= len) begin
                            n_status = ST_OK;
                            out_poff = poff;
                            out_plen = len - {8'd0, poff};
                        end
                    end
                end
            end
        end

        n_data = '0;
        n_data[243:220] = {out_plen, out_poff};
        if (eth_vis) begin
            n_data[111:0] = {i_frame.ether_type, i_frame.src_mac, i_frame.dst_mac};
        end
        if (ip_vis) begin
            n_data[183:112] = {i_frame.dst_ip, i_frame.src_ip, i_frame.protocol};
        end
        if (tcp_vis) begin
            n_data[219:184] = {i_frame.flags, i_frame.tcp_dport, i_frame.tcp_sport};
        end
    end

    // output register takes a new item whenever it is empty or being drained
    assign o_pop = i_valid && (!r_valid || i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_tready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data   <= n_data;
            r_status <= n_status;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_status;

endmodule

FILE: rtl/eth_ipv4_tcp_header_parser.sv
// channel   dir  signals                           item
// s_axis    in   tvalid tready tdata[7:0] tlast    one frame byte, tlast on final byte
// m_axis    out  tvalid tready tdata[247:0] tuser  one parse result per frame
//
// one byte accepted per cycle while the queue has room; m_axis_tvalid rises after
// the frame passes the queue write and then the evaluate register
// a two-entry frame queue sits between capture and evaluation, so s_axis only
// stalls when the queue is full, i.e. after m_axis has held back three results
// synchronous active-low reset clears the byte counter, captured fields and queue
module eth_ipv4_tcp_header_parser #(
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [ethp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // byte_value
    input  logic         s_axis_tlast,  // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // dst_mac[47:0] src_mac[95:48] ether_type[111:96] ip_protocol[119:112]
    // src_ip[151:120] dst_ip[183:152] tcp_sport[199:184] tcp_dport[215:200]
    // tcp_flags[219:216] payload_offset[227:220] payload_length[243:228]
    output logic [ethp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser   // status
);
    import ethp_pkg::*;

    logic   accept;
    logic   push;
    logic   q_full;
    logic   q_valid;
    logic   pop;
    t_frame front_frame;
    t_frame head_frame;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ethp_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (push),
        .o_frame  (front_frame)
    );

    ethp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (front_frame),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_frame (head_frame)
    );

    ethp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_frame  (head_frame),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

FILE: verif/eth_ipv4_tcp_header_parser_tb.sv
`timescale 1ns / 1ps

module eth_ipv4_tcp_header_parser_tb;
    import ethp_pkg::*;

    localparam int MAX_FRAME  = 65535;
    localparam int IP_HDR_MIN = 20;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] tcp_sport;
        logic [15:0] tcp_dport;
        logic [3:0]  tcp_flags;
        logic [7:0]  payload_offset;
        logic [15:0] payload_length;
    } t_parse_result;

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'h00;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [247:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    // header fields captured so far in the current frame
    logic [15:0]  rx_len;
    logic [47:0]  cap_dst_mac;
    logic [47:0]  cap_src_mac;
    logic [15:0]  cap_ether_type;
    logic [7:0]   cap_ver_ihl;
    logic [7:0]   cap_protocol;
    logic [31:0]  cap_src_ip;
    logic [31:0]  cap_dst_ip;
    logic [15:0]  cap_tcp_sport;
    logic [15:0]  cap_tcp_dport;
    logic [3:0]   cap_data_off;
    logic [3:0]   cap_flags;

    t_parse_result expected_results[$];
    logic [7:0]    frame_bytes[$];
    int            mismatch_count = 0;
    int            bytes_sent     = 0;
    int            frames_sent    = 0;
    int            src_idle_pct   = 0;
    int            sink_idle_pct  = 0;

    eth_ipv4_tcp_header_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void clear_capture();
        rx_len         = '0;
        cap_dst_mac    = '0;
        cap_src_mac    = '0;
        cap_ether_type = '0;
        cap_ver_ihl    = '0;
        cap_protocol   = '0;
        cap_src_ip     = '0;
        cap_dst_ip     = '0;
        cap_tcp_sport  = '0;
        cap_tcp_dport  = '0;
        cap_data_off   = '0;
        cap_flags      = '0;
    endfunction

    function automatic void absorb_frame_byte(input logic [7:0] value);
        logic [15:0] pos;
        logic [15:0] tcp_base;
        pos = rx_len;
        if (pos < POS_SRC_MAC) begin
            cap_dst_mac = {cap_dst_mac[39:0], value};
        end else if (pos < POS_ETYPE) begin
            cap_src_mac = {cap_src_mac[39:0], value};
        end else if (pos < POS_VER_IHL) begin
            cap_ether_type = {cap_ether_type[7:0], value};
        end else if (pos == POS_VER_IHL) begin
            cap_ver_ihl = value;
        end else if (pos == POS_PROTO) begin
            cap_protocol = value;
        end else if (pos >= POS_SRC_IP && pos < POS_DST_IP) begin
            cap_src_ip = {cap_src_ip[23:0], value};
        end else if (pos >= POS_DST_IP && pos < POS_IP_END) begin
            cap_dst_ip = {cap_dst_ip[23:0], value};
        end
        // tcp fields move with the ip header length
        if (pos > POS_VER_IHL && cap_ver_ihl[3:0] >= HDR_MIN_WORDS) begin
            tcp_base = 16'(ETH_LEN) + {10'd0, cap_ver_ihl[3:0], 2'b00};
            if (pos == tcp_base || pos == tcp_base + 16'd1) begin
                cap_tcp_sport = {cap_tcp_sport[7:0], value};
            end else if (pos == tcp_base + 16'(TCP_DPORT) ||
                         pos == tcp_base + 16'(TCP_DPORT) + 16'd1) begin
                cap_tcp_dport = {cap_tcp_dport[7:0], value};
            end else if (pos == tcp_base + 16'(TCP_DOFF)) begin
                cap_data_off = value[7:4];
            end else if (pos == tcp_base + 16'(TCP_FLAGS)) begin
                cap_flags = {value[4], value[2:0]};
            end
        end
        if (rx_len != 16'(MAX_FRAME))
            rx_len = rx_len + 16'd1;
    endfunction

    function automatic t_parse_result close_frame();
        t_parse_result r;
        int len, l2, l3, ihl_bytes, doff_bytes, off;
        r         = '0;
        r.status  = ST_ETH;
        len       = int'(rx_len);
        ihl_bytes = 4 * int'(cap_ver_ihl[3:0]);
        doff_bytes = 4 * int'(cap_data_off);
        if (len >= int'(ETH_LEN)) begin
            r.dst_mac    = cap_dst_mac;
            r.src_mac    = cap_src_mac;
            r.ether_type = cap_ether_type;
            if (cap_ether_type == ETYPE_IPV4) begin
                l2       = len - int'(ETH_LEN);
                r.status = ST_IP;
                if (l2 >= IP_HDR_MIN && cap_ver_ihl[7:4] == IP_VERSION4) begin
                    r.ip_protocol = cap_protocol;
                    r.src_ip      = cap_src_ip;
                    r.dst_ip      = cap_dst_ip;
                    if (cap_ver_ihl[3:0] >= HDR_MIN_WORDS && ihl_bytes <= l2) begin
                        l3       = l2 - ihl_bytes;
                        r.status = ST_TCP;
                        if (cap_protocol == PROTO_TCP && l3 >= int'(TCP_MIN)) begin
                            r.tcp_sport = cap_tcp_sport;
                            r.tcp_dport = cap_tcp_dport;
                            r.tcp_flags = cap_flags;
                            if (cap_data_off >= HDR_MIN_WORDS && doff_bytes <= l3) begin
                                off              = int'(ETH_LEN) + ihl_bytes + doff_bytes;
                                r.status         = ST_OK;
                                r.payload_offset = 8'(off);
                                r.payload_length = 16'(len - off);
                            end
                        end
                    end
                end
            end
        end
        clear_capture();
        return r;
    endfunction

    initial clear_capture();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 100)
            $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_parse_result want;
        t_parse_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status         = m_axis_tuser;
            got.dst_mac        = m_axis_tdata[47:0];
            got.src_mac        = m_axis_tdata[95:48];
            got.ether_type     = m_axis_tdata[111:96];
            got.ip_protocol    = m_axis_tdata[119:112];
            got.src_ip         = m_axis_tdata[151:120];
            got.dst_ip         = m_axis_tdata[183:152];
            got.tcp_sport      = m_axis_tdata[199:184];
            got.tcp_dport      = m_axis_tdata[215:200];
            got.tcp_flags      = m_axis_tdata[219:216];
            got.payload_offset = m_axis_tdata[227:220];
            got.payload_length = m_axis_tdata[243:228];
            if (expected_results.size() == 0) begin
                report_mismatch("result with no frame pending", 64'(got.status), 64'd0);
            end else begin
                want = expected_results.pop_front();
                check_field("status", 64'(got.status), 64'(want.status));
                check_field("dst_mac", 64'(got.dst_mac), 64'(want.dst_mac));
                check_field("src_mac", 64'(got.src_mac), 64'(want.src_mac));
                check_field("ether_type", 64'(got.ether_type), 64'(want.ether_type));
                check_field("ip_protocol", 64'(got.ip_protocol), 64'(want.ip_protocol));
                check_field("src_ip", 64'(got.src_ip), 64'(want.src_ip));
                check_field("dst_ip", 64'(got.dst_ip), 64'(want.dst_ip));
                check_field("tcp_sport", 64'(got.tcp_sport), 64'(want.tcp_sport));
                check_field("tcp_dport", 64'(got.tcp_dport), 64'(want.tcp_dport));
                check_field("tcp_flags", 64'(got.tcp_flags), 64'(want.tcp_flags));
                check_field("payload_offset", 64'(got.payload_offset),
                            64'(want.payload_offset));
                check_field("payload_length", 64'(got.payload_length),
                            64'(want.payload_length));
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_frame_byte(value);
        if (last)
            expected_results.push_back(close_frame());
        bytes_sent++;
    endtask

    function automatic logic [7:0] fill_byte(input int fill);
        return (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
    endfunction

    // fill < 0 gives random content, otherwise every free byte takes that value
    function automatic void build_frame(input logic [15:0] etype, input logic [3:0] ver,
                                        input logic [3:0] ihl, input logic [7:0] proto,
                                        input logic [3:0] doff, input int pay_len,
                                        input int fill);
        int ip_len, tcp_len;
        logic [7:0] b;
        frame_bytes.delete();
        ip_len  = (ihl < HDR_MIN_WORDS) ? IP_HDR_MIN : 4 * int'(ihl);
        tcp_len = (doff < HDR_MIN_WORDS) ? int'(TCP_MIN) : 4 * int'(doff);
        for (int i = 0; i < 12; i++)
            frame_bytes.push_back(fill_byte(fill));
        frame_bytes.push_back(etype[15:8]);
        frame_bytes.push_back(etype[7:0]);
        frame_bytes.push_back({ver, ihl});
        for (int i = 1; i < ip_len; i++)
            frame_bytes.push_back((i == 9) ? proto : fill_byte(fill));
        for (int i = 0; i < tcp_len; i++) begin
            b = fill_byte(fill);
            if (i == int'(TCP_DOFF))
                b[7:4] = doff;
            frame_bytes.push_back(b);
        end
        for (int i = 0; i < pay_len; i++)
            frame_bytes.push_back(fill_byte(fill));
    endfunction

    // sends len bytes of the built frame, random bytes past its end
    task automatic send_frame(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = (i < frame_bytes.size()) ? frame_bytes[i] : 8'($urandom_range(255));
            send_byte(b, i == len - 1);
        end
        frames_sent++;
    endtask

    task automatic test_reference_frames();
        build_frame(ETYPE_IPV4, IP_VERSION4, HDR_MIN_WORDS, PROTO_TCP, HDR_MIN_WORDS, 0, -1);
        send_frame(frame_bytes.size());
        build_frame(ETYPE_IPV4, IP_VERSION4, HDR_MIN_WORDS, PROTO_TCP, HDR_MIN_WORDS, 3, 0);
        send_frame(frame_bytes.size());
        // largest headers, all flags set
        build_frame(ETYPE_IPV4, IP_VERSION4, 4'd15, PROTO_TCP, 4'd15, 5, 255);
        send_frame(frame_bytes.size());
        build_frame(ETYPE_IPV4, IP_VERSION4, 4'd7, PROTO_TCP, 4'd9, 20, -1);
        send_frame(frame_bytes.size());
    endtask

    task automatic test_truncated_frames();
        int cuts[8] = '{1, 13, 14, 33, 34, 53, 54, 57};
        build_frame(ETYPE_IPV4, IP_VERSION4, HDR_MIN_WORDS, PROTO_TCP, HDR_MIN_WORDS, 4, -1);
        foreach (cuts[i])
            send_frame(cuts[i]);
        // ip header longer than what follows the ethernet header
        build_frame(ETYPE_IPV4, IP_VERSION4, 4'd6, PROTO_TCP, HDR_MIN_WORDS, 0, -1);
        send_frame(37);
        // tcp data offset reaching past the frame end
        build_frame(ETYPE_IPV4, IP_VERSION4, HDR_MIN_WORDS, PROTO_TCP, 4'd8, 0, -1);
        send_frame(65);
    endtask

    task automatic test_header_faults();
        build_frame(16'h86DD, IP_VERSION4, HDR_MIN_WORDS, PROTO_TCP, HDR_MIN_WORDS, 2, -1);
        send_frame(frame_bytes.size());
        build_frame(16'h0801, IP_VERSION4, HDR_MIN_WORDS, PROTO_TCP, HDR_MIN_WORDS, 2, -1);
        send_frame(frame_bytes.size());
        build_frame(ETYPE_IPV4, 4'd6, HDR_MIN_WORDS, PROTO_TCP, HDR_MIN_WORDS, 2, -1);
        send_frame(frame_bytes.size());
        build_frame(ETYPE_IPV4, IP_VERSION4, 4'd0, PROTO_TCP, HDR_MIN_WORDS, 2, -1);
        send_frame(frame_bytes.size());
        build_frame(ETYPE_IPV4, IP_VERSION4, 4'd4, PROTO_TCP, HDR_MIN_WORDS, 2, -1);
        send_frame(frame_bytes.size());
        build_frame(ETYPE_IPV4, IP_VERSION4, HDR_MIN_WORDS, 8'd17, HDR_MIN_WORDS, 2, -1);
        send_frame(frame_bytes.size());
        build_frame(ETYPE_IPV4, IP_VERSION4, HDR_MIN_WORDS, PROTO_TCP, 4'd0, 2, -1);
        send_frame(frame_bytes.size());
        build_frame(ETYPE_IPV4, IP_VERSION4, HDR_MIN_WORDS, PROTO_TCP, 4'd4, 2, -1);
        send_frame(frame_bytes.size());
    endtask

    task automatic send_random_frame();
        int kind, len, tcp_base, pay_len;
        logic [15:0] etype;
        logic [3:0]  ver, ihl, doff;
        logic [7:0]  proto;
        kind  = $urandom_range(99);
        etype = ETYPE_IPV4;
        ver   = IP_VERSION4;
        proto = PROTO_TCP;
        ihl   = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 5)) : HDR_MIN_WORDS;
        doff  = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 5)) : HDR_MIN_WORDS;
        if (kind >= 80 && kind < 95) begin
            case ($urandom_range(4))
                0: begin
                    etype = 16'($urandom);
                end
                1: begin
                    ver = 4'($urandom);
                end
                2: begin
                    ihl = 4'($urandom_range(4));
                end
                3: begin
                    proto = 8'($urandom);
                end
                default: begin
                    doff = 4'($urandom_range(4));
                end
            endcase
        end
        pay_len = ($urandom_range(7) == 0) ? $urandom_range(200) : $urandom_range(16);
        build_frame(etype, ver, ihl, proto, doff, pay_len, -1);
        len = frame_bytes.size();
        if (kind >= 95) begin
            // pure noise
            frame_bytes.delete();
            len = $urandom_range(100, 1);
        end else if (kind >= 60 && kind < 80) begin
            // cut the frame near a layer boundary, or at a random length
            tcp_base = int'(ETH_LEN) + 4 * int'(ihl);
            case ($urandom_range(5))
                0: begin
                    len = $urandom_range(15, 1);
                end
                1: begin
                    len = $urandom_range(35, 32);
                end
                2: begin
                    len = tcp_base - 1 + $urandom_range(2);
                end
                3: begin
                    len = tcp_base + 19 + $urandom_range(1);
                end
                4: begin
                    len = tcp_base + 4 * int'(doff) - 1 + $urandom_range(1);
                end
                default: begin
                    len = $urandom_range(len, 1);
                end
            endcase
        end
        send_frame(len);
    endtask

    task automatic test_random_traffic(input int min_frames, input int min_bytes);
        int frames_at_start, bytes_at_start;
        frames_at_start = frames_sent;
        bytes_at_start  = bytes_sent;
        while (frames_sent - frames_at_start < min_frames ||
               bytes_sent - bytes_at_start < min_bytes)
            send_random_frame();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 7;
        sink_idle_pct = 76;
        test_reference_frames();
        test_truncated_frames();
        test_header_faults();
        test_random_traffic(3, 200);

        src_idle_pct  = 76;
        sink_idle_pct = 7;
        test_random_traffic(3, 200);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(3, 200);

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
